### hw/rtl/clab_pkg.sv
// clab_pkg: shared types, widths and the fixed class-to-label table of the
// class logit argmax labeler. No dependencies.
package clab_pkg;

   localparam int LOGIT_W     = 16;  // signed Q8.8
   localparam int CLASS_W     = 8;   // raw class index, up to 256 classes
   localparam int COUNT_W     = 9;   // class_count register width
   localparam int LABEL_W     = 4;   // pixel_label width
   localparam int TABLE_SIZE  = 150;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr bit 2
   localparam logic REG_CLASS_COUNT = 1'b0;
   localparam logic REG_THRESHOLD   = 1'b1;

   localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = 9'd150;
   localparam logic signed [LOGIT_W-1:0] THRESHOLD_RESET = 16'sd128;

   // finished pixel, handed from front to back through the queue
   typedef struct packed {
      logic signed [LOGIT_W-1:0] best_logit;
      logic [CLASS_W-1:0]        win_class;
      logic                      clear_set;   // frame start seen since the last pixel
      logic                      last_pixel;
   } pixel_type;

   localparam logic [LABEL_W-1:0] LABEL_TABLE [0:TABLE_SIZE-1] = '{
      4'd2,  4'd2,  4'd0,  4'd1,  4'd9,  4'd3,  4'd1,  4'd6,  4'd5,  4'd9,
      4'd6,  4'd1,  4'd7,  4'd0,  4'd4,  4'd11, 4'd0,  4'd9,  4'd0,  4'd12,
      4'd8,  4'd0,  4'd0,  4'd6,  4'd6,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,
      4'd0,  4'd0,  4'd0,  4'd6,  4'd0,  4'd6,  4'd6,  4'd6,  4'd0,  4'd0,
      4'd0,  4'd13, 4'd0,  4'd0,  4'd6,  4'd0,  4'd0,  4'd6,  4'd0,  4'd6,
      4'd6,  4'd0,  4'd0,  4'd10, 4'd0,  4'd0,  4'd11, 4'd6,  4'd4,  4'd10,
      4'd0,  4'd0,  4'd6,  4'd0,  4'd11, 4'd6,  4'd9,  4'd0,  4'd0,  4'd6,
      4'd0,  4'd6,  4'd9,  4'd6,  4'd6,  4'd12, 4'd0,  4'd0,  4'd0,  4'd0,
      4'd8,  4'd0,  4'd0,  4'd8,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd6,
      4'd8,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd10, 4'd6,  4'd6,  4'd6,
      4'd0,  4'd0,  4'd8,  4'd8,  4'd0,  4'd0,  4'd0,  4'd6,  4'd6,  4'd0,
      4'd12, 4'd6,  4'd6,  4'd0,  4'd0,  4'd6,  4'd8,  4'd6,  4'd6,  4'd0,
      4'd6,  4'd10, 4'd8,  4'd0,  4'd6,  4'd6,  4'd0,  4'd8,  4'd0,  4'd6,
      4'd6,  4'd6,  4'd6,  4'd0,  4'd0,  4'd6,  4'd0,  4'd0,  4'd0,  4'd0,
      4'd0,  4'd0,  4'd0,  4'd6,  4'd0,  4'd6,  4'd6,  4'd0,  4'd6,  4'd0
   };

endpackage

### hw/rtl/class_logit_argmax_labeler.sv
// class_logit_argmax_labeler: top level with the register port, the
// argmax front, the pixel queue and the labeling back end.
// Depends on clab_pkg, clab_front, clab_queue and clab_back.
//
//   channel   direction  transaction                         handshake
//   req_*     in         one class logit of a pixel          req_valid / req_stall
//   rsp_*     out        one labeled pixel                   rsp_valid / rsp_stall
//   csr_*     in/out     register write or read              psel / penable, pready=1
//
// Throughput is one logit per cycle while req_stall is low; the front does one compare and update
// per class. After its final logit, a pixel's result passes into the two-entry queue
// and then into the result register.
// Reset (synchronous) sets class_count to 150, the threshold to 0.5 and the
// presence set to label 0 only; the queue starts empty.
// req_stall rises only when the queue is full and the back end cannot drain,
// which follows from a held rsp_stall.
module class_logit_argmax_labeler #(
   parameter int LABEL_COUNT = 14,
   parameter int MAX_CLASSES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [clab_pkg::LOGIT_W-1:0]  req_logit_value,
   input  logic                                 req_frame_start,
   input  logic                                 req_last_pixel,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [clab_pkg::LABEL_W-1:0]         rsp_pixel_label,
   output logic signed [clab_pkg::LOGIT_W-1:0]  rsp_pixel_confidence,
   output logic [LABEL_COUNT-1:0]               rsp_present_labels,
   output logic                                 rsp_frame_done,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [clab_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [clab_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [clab_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [clab_pkg::COUNT_W-1:0]        class_count_ff, class_count_in;
   logic signed [clab_pkg::LOGIT_W-1:0] threshold_ff, threshold_in;
   logic                                csr_write;
   logic                                reg_sel;

   logic                item_accept;
   logic                push;
   clab_pkg::pixel_type push_pixel;
   logic                can_push;
   logic                pop;
   logic                head_valid;
   clab_pkg::pixel_type head_pixel;

   // ---------------- register port ----------------
   // Decode the register from address bit 2; the low byte bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      class_count_in = class_count_ff;
      threshold_in   = threshold_ff;
      if (csr_write) begin
         unique case (reg_sel)
            clab_pkg::REG_CLASS_COUNT: class_count_in = csr_pwdata[clab_pkg::COUNT_W-1:0];
            clab_pkg::REG_THRESHOLD:   threshold_in   = csr_pwdata[clab_pkg::LOGIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         clab_pkg::REG_CLASS_COUNT: csr_prdata = clab_pkg::CSR_DATA_W'(class_count_ff);
         clab_pkg::REG_THRESHOLD:   csr_prdata = clab_pkg::CSR_DATA_W'(
                                       $unsigned(threshold_ff));
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= clab_pkg::CLASS_COUNT_RESET;
         threshold_ff   <= clab_pkg::THRESHOLD_RESET;
      end else begin
         class_count_ff <= class_count_in;
         threshold_ff   <= threshold_in;
      end
   end

   // ---------------- input handshake ----------------
   // Stall whenever the queue has no free slot, even for a logit that ends no pixel.
   assign req_stall   = ~can_push;
   assign item_accept = req_valid & ~req_stall;

   // ---------------- front: class count and running argmax ----------------
   clab_front #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .logit_value (req_logit_value),
      .frame_start (req_frame_start),
      .last_pixel  (req_last_pixel),
      .class_count (class_count_ff),
      .push        (push),
      .push_pixel  (push_pixel)
   );

   // ---------------- queue of finished pixels ----------------
   clab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_pixel (push_pixel),
      .can_push   (can_push),
      .pop        (pop),
      .head_valid (head_valid),
      .head_pixel (head_pixel)
   );

   // ---------------- back: label map, presence set, result register ----------------
   clab_back #(
      .LABEL_COUNT (LABEL_COUNT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_pixel           (head_pixel),
      .pop                  (pop),
      .threshold            (threshold_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pixel_label      (rsp_pixel_label),
      .rsp_pixel_confidence (rsp_pixel_confidence),
      .rsp_present_labels   (rsp_present_labels),
      .rsp_frame_done       (rsp_frame_done)
   );

endmodule

### hw/rtl/clab_front.sv
// clab_front: counts classes, keeps the running argmax of a pixel and emits one finished
// pixel per class_count logits, class_count clamped to 1..MAX_CLASSES. Uses clab_pkg.
module clab_front #(
   parameter int MAX_CLASSES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_accept,
   input  logic signed [clab_pkg::LOGIT_W-1:0]  logit_value,
   input  logic                                 frame_start,
   input  logic                                 last_pixel,
   input  logic [clab_pkg::COUNT_W-1:0]         class_count,
   output logic                                 push,
   output clab_pkg::pixel_type                  push_pixel
);

   localparam int POS_W = $clog2(MAX_CLASSES);
   localparam logic [clab_pkg::COUNT_W-1:0] MAX_COUNT = clab_pkg::COUNT_W'(MAX_CLASSES);

   logic [POS_W-1:0]                    pos_ff, pos_in;
   logic signed [clab_pkg::LOGIT_W-1:0] best_logit_ff, best_logit_in;
   logic [POS_W-1:0]                    win_class_ff, win_class_in;
   logic                                clear_pend_ff, clear_pend_in;

   logic [clab_pkg::COUNT_W-1:0] count_eff;
   logic                         take;
   logic                         clear_now;
   logic                         pixel_end;

   always_comb begin
      if (class_count == '0) begin
         count_eff = clab_pkg::COUNT_W'(1);
      end else if (class_count > MAX_COUNT) begin
         count_eff = MAX_COUNT;
      end else begin
         count_eff = class_count;
      end
   end

   // first class always wins; later ones only when strictly larger
   assign take          = (pos_ff == '0) || (logit_value > best_logit_ff);
   assign best_logit_in = take ? logit_value : best_logit_ff;
   assign win_class_in  = take ? pos_ff : win_class_ff;
   assign clear_now     = clear_pend_ff | frame_start;
   assign pixel_end     = (clab_pkg::COUNT_W'(pos_ff) + clab_pkg::COUNT_W'(1)) >= count_eff;

   always_comb begin
      pos_in        = pos_ff;
      clear_pend_in = clear_pend_ff;
      if (item_accept) begin
         if (pixel_end) begin
            pos_in        = '0;
            clear_pend_in = 1'b0;
         end else begin
            pos_in        = pos_ff + POS_W'(1);
            clear_pend_in = clear_now;
         end
      end
   end

   assign push                  = item_accept & pixel_end;
   assign push_pixel.best_logit = best_logit_in;
   assign push_pixel.win_class  = clab_pkg::CLASS_W'(win_class_in);
   assign push_pixel.clear_set  = clear_now;
   assign push_pixel.last_pixel = last_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         clear_pend_ff <= 1'b0;
         best_logit_ff <= '0;
         win_class_ff  <= '0;
      end else begin
         pos_ff        <= pos_in;
         clear_pend_ff <= clear_pend_in;
         if (item_accept) begin
            best_logit_ff <= best_logit_in;
            win_class_ff  <= win_class_in;
         end
      end
   end

endmodule

### hw/rtl/clab_queue.sv
// clab_queue: short FIFO of finished pixels between front and back.
// Uses clab_pkg.
module clab_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  clab_pkg::pixel_type push_pixel,
   output logic                can_push,
   input  logic                pop,
   output logic                head_valid,
   output clab_pkg::pixel_type head_pixel
);

   clab_pkg::pixel_type             slot_ff [clab_pkg::QUEUE_DEPTH];
   logic [clab_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [clab_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [clab_pkg::QCNT_W-1:0]     fill_ff, fill_in;
   logic                            do_push;
   logic                            do_pop;

   assign head_valid = (fill_ff != '0);
   assign head_pixel = slot_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;
   // a slot frees in the same cycle when the back side drains one
   assign can_push   = (fill_ff != clab_pkg::QCNT_W'(clab_pkg::QUEUE_DEPTH)) | do_pop;
   assign do_push    = push & can_push;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + clab_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + clab_pkg::QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + clab_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - clab_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### hw/rtl/clab_back.sv
// clab_back: maps the winning class to a label, updates the per-frame
// presence set and holds the result register. Uses clab_pkg.
module clab_back #(
   parameter int LABEL_COUNT = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  clab_pkg::pixel_type                  head_pixel,
   output logic                                 pop,
   input  logic signed [clab_pkg::LOGIT_W-1:0]  threshold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [clab_pkg::LABEL_W-1:0]         rsp_pixel_label,
   output logic signed [clab_pkg::LOGIT_W-1:0]  rsp_pixel_confidence,
   output logic [LABEL_COUNT-1:0]               rsp_present_labels,
   output logic                                 rsp_frame_done
);

   localparam logic [LABEL_COUNT-1:0] LABEL_ZERO_BIT = LABEL_COUNT'(1);

   logic [LABEL_COUNT-1:0]              presence_ff, presence_in;
   logic                                valid_ff, valid_in;
   logic [clab_pkg::LABEL_W-1:0]        label_ff;
   logic signed [clab_pkg::LOGIT_W-1:0] conf_ff;
   logic                                done_ff;

   logic [clab_pkg::LABEL_W-1:0] table_label;
   logic [clab_pkg::LABEL_W-1:0] label;
   logic [LABEL_COUNT-1:0]       base_set;
   logic                         hit;

   assign pop = head_valid & (~valid_ff | ~rsp_stall);

   always_comb begin
      if (head_pixel.win_class < clab_pkg::CLASS_W'(clab_pkg::TABLE_SIZE)) begin
         table_label = clab_pkg::LABEL_TABLE[head_pixel.win_class];
      end else begin
         table_label = '0;
      end
      label = (32'(table_label) >= LABEL_COUNT) ? '0 : table_label;
   end

   assign base_set = head_pixel.clear_set ? LABEL_ZERO_BIT : presence_ff;
   assign hit      = head_pixel.best_logit >= threshold;

   always_comb begin
      presence_in = presence_ff;
      valid_in    = valid_ff & rsp_stall;
      if (pop) begin
         presence_in = base_set | LABEL_ZERO_BIT | (hit ? (LABEL_ZERO_BIT << label) : '0);
         valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presence_ff <= LABEL_ZERO_BIT;
         valid_ff    <= 1'b0;
      end else begin
         presence_ff <= presence_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         label_ff <= label;
         conf_ff  <= head_pixel.best_logit;
         done_ff  <= head_pixel.last_pixel;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_pixel_label      = label_ff;
   assign rsp_pixel_confidence = conf_ff;
   assign rsp_present_labels   = presence_ff;
   assign rsp_frame_done       = done_ff;

endmodule
